/* hw/rtl/rmss_pkg.sv */
// shared constants, codes and control types for the range max subarray sum unit
package rmss_pkg;

  // store geometry
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DEPTH_W = $clog2(DEPTH + 1);

  // item field widths
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int RANGE_W = 11;
  localparam int SUM_W   = 48;

  // packed stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  // most negative sum, reported for an empty range
  localparam logic signed [SUM_W-1:0] SUM_MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

  // item kinds carried on in_tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;     // store the write transfer's element
    logic start;     // latch the query range and clear the accumulators
    logic issue;     // read the element at the scan address and step it
    logic load_out;  // move the finished result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_empty;  // clamped range of the incoming query holds nothing
    logic issue_last;   // scan address sits on the last element of the range
    logic out_busy;     // output register holds a result that is not taken now
  } dp_status_t;

endpackage

/* hw/rtl/rmss_ctrl.sv */
// controller state machine that sequences writes, range scans and result hand-off
module rmss_ctrl
  import rmss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  opcode_t    opcode,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd          = '0;
    in_fire      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        in_fire   = in_tvalid;
        if (in_fire) begin
          if (opcode == OP_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = status.range_empty ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last element read is folded into the sums at this edge
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/rmss_dp.sv */
// datapath: element memory, scan address counter, running sums and output register
module rmss_dp
  import rmss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic [IDX_W-1:0]        elem_index,
  input  logic signed [VAL_W-1:0] elem_value,
  input  logic [RANGE_W-1:0]      range_begin,
  input  logic [RANGE_W-1:0]      range_end,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic signed [SUM_W-1:0] best_sum,
  output logic                    range_empty
);

  logic [VAL_W-1:0] mem [DEPTH];

  logic [RANGE_W-1:0]      first_pos;
  logic [RANGE_W-1:0]      last_pos;
  logic                    wr_in_range;

  logic [ADDR_W-1:0]       addr_r;
  logic [ADDR_W-1:0]       last_addr_r;
  logic                    rd_vld_r;
  logic signed [VAL_W-1:0] rd_data_r;

  logic signed [SUM_W-1:0] run_r;
  logic signed [SUM_W-1:0] best_r;
  logic                    empty_r;
  logic signed [SUM_W-1:0] sum;

  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_empty_r;

  // clamp the one-based range to the store
  always_comb begin
    first_pos = (range_begin == '0) ? RANGE_W'(1) : range_begin;
    last_pos  = (range_end > RANGE_W'(DEPTH)) ? RANGE_W'(DEPTH) : range_end;
  end

  assign wr_in_range = (DEPTH_W'(elem_index) < DEPTH_W'(DEPTH));

  // element memory, at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in_range) begin
      mem[ADDR_W'(elem_index)] <= elem_value;
    end
    rd_data_r <= mem[addr_r];
  end

  // read-valid flag is the issue command registered, so it is high in the cycle after each issued address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  // scan address counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_r      <= ADDR_W'(first_pos - RANGE_W'(1));
      last_addr_r <= ADDR_W'(last_pos - RANGE_W'(1));
    end else if (cmd.issue) begin
      addr_r <= addr_r + ADDR_W'(1);
    end
  end

  // running sum step
  assign sum = run_r + SUM_W'(rd_data_r);

  // running and best sums
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      run_r   <= '0;
      best_r  <= SUM_MOST_NEG;
      empty_r <= 1'b1;
    end else if (rd_vld_r) begin
      if (empty_r || (sum > best_r)) begin
        best_r <= sum;
      end
      run_r   <= sum[SUM_W-1] ? '0 : sum;
      empty_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sum_r   <= best_r;
      out_empty_r <= empty_r;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign best_sum    = out_sum_r;
  assign range_empty = out_empty_r;

  // status back to the controller
  always_comb begin
    status.range_empty = (first_pos > last_pos);
    status.issue_last  = (addr_r == last_addr_r);
    status.out_busy    = out_valid_r && !out_tready;
  end

endmodule

/* hw/rtl/range_max_subarray_sum_unit.sv */
// Range max subarray sum unit: write transfers are accepted back to back.
// A query holds the input while it scans its range, one memory read per cycle through
// the single element port; a flush state then folds in the last read and a done state
// loads the result once the output register is free. An empty range skips the scan. The result
// waits in an output register, so the input reopens while it is not yet taken. Reset (rst_n low,
// synchronous) clears control state only; the element memory is undefined until written.
module range_max_subarray_sum_unit
  import rmss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // elem_index, elem_value, range_begin, range_end
  input  logic                  in_tuser,   // opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // best_sum
  output logic                  out_tuser   // range_empty
);

  dp_cmd_t                 cmd;
  dp_status_t              status;
  opcode_t                 opcode;
  logic [IDX_W-1:0]        elem_index;
  logic signed [VAL_W-1:0] elem_value;
  logic [RANGE_W-1:0]      range_begin;
  logic [RANGE_W-1:0]      range_end;
  logic signed [SUM_W-1:0] best_sum;

  // unpack the input transfer
  assign opcode      = opcode_t'(in_tuser);
  assign elem_index  = in_tdata[IDX_W-1:0];
  assign elem_value  = in_tdata[IDX_W+VAL_W-1:IDX_W];
  assign range_begin = in_tdata[IDX_W+VAL_W+RANGE_W-1:IDX_W+VAL_W];
  assign range_end   = in_tdata[IDX_W+VAL_W+2*RANGE_W-1:IDX_W+VAL_W+RANGE_W];

  rmss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .opcode    (opcode),
    .status    (status),
    .cmd       (cmd)
  );

  rmss_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .elem_index  (elem_index),
    .elem_value  (elem_value),
    .range_begin (range_begin),
    .range_end   (range_end),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .best_sum    (best_sum),
    .range_empty (out_tuser)
  );

  // pack the result transfer
  assign out_tdata = best_sum;

endmodule

/* sim/testbench.sv */
// self-checking testbench for the range max subarray sum unit: element writes and range queries
module testbench
  import rmss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_ITEMS   = 80;       // last part of the run is driven without idling
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANGE_TOP    = (1 << RANGE_W) - 1;
  localparam int PRINT_CAP    = 50;

  // one input transfer
  typedef struct {
    opcode_t             op;
    logic [IDX_W-1:0]    idx;
    logic [VAL_W-1:0]    val;
    logic [RANGE_W-1:0]  rbeg;
    logic [RANGE_W-1:0]  rend;
  } unit_item_t;

  // one expected query answer
  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             empty;
  } range_sum_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // elem_index, elem_value, range_begin, range_end
  logic                  in_tuser = 1'b0; // opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // best_sum
  logic                  out_tuser;       // range_empty

  range_max_subarray_sum_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // stimulus queue and generator bookkeeping
  unit_item_t pending_items[$];
  bit         filled[DEPTH];
  int         filled_list[$];
  int         frontier = 0;
  int         items_built = 0;

  // shadow of the element store and the answers still owed
  int         shadow_store[DEPTH];
  range_sum_t sums_due[$];

  unit_item_t cur_item;
  logic       in_fire = 1'b0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         in_idle_mode = 1'b1;
  bit         out_idle_mode = 1'b1;

  int         cycle_count = 0;
  int         mismatches = 0;
  int         writes_done = 0;
  int         queries_done = 0;
  int         empties_checked = 0;
  int         sums_checked = 0;
  int         widest_scan = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  task automatic add_write(input int idx, input logic [VAL_W-1:0] v);
    unit_item_t it;
    it.op   = OP_WRITE;
    it.idx  = IDX_W'(idx);
    it.val  = v;
    it.rbeg = RANGE_W'($urandom);
    it.rend = RANGE_W'($urandom);
    pending_items.push_back(it);
    if (!filled[idx]) begin
      filled[idx] = 1'b1;
      filled_list.push_back(idx);
    end
    items_built++;
  endtask

  task automatic add_query(input int b, input int e);
    unit_item_t it;
    it.op   = OP_QUERY;
    it.idx  = IDX_W'($urandom);
    it.val  = $urandom;
    it.rbeg = RANGE_W'(b);
    it.rend = RANGE_W'(e);
    pending_items.push_back(it);
    items_built++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return VAL_W'($urandom_range(0, 200) - 100);
      5:       return VAL_W'(-$urandom_range(1, 1000000));
      default: return $urandom;
    endcase
  endfunction

  // query over a stretch of written elements around a random written anchor
  task automatic add_span_query();
    int anchor, lo, hi, want, b, e;
    anchor = filled_list[$urandom_range(0, filled_list.size() - 1)];
    want = ($urandom_range(0, 9) == 0) ? $urandom_range(1, DEPTH) : $urandom_range(1, 24);
    lo = anchor;
    hi = anchor;
    while (hi - lo + 1 < want && hi < DEPTH - 1 && filled[hi + 1]) hi++;
    while (hi - lo + 1 < want && lo > 0 && filled[lo - 1]) lo--;
    b = lo + 1;
    e = hi + 1;
    // begin below one and end past the store both clamp
    if (lo == 0 && $urandom_range(0, 3) == 0) b = 0;
    if (hi == DEPTH - 1 && $urandom_range(0, 1) == 0) e = $urandom_range(DEPTH, RANGE_TOP);
    add_query(b, e);
  endtask

  // ranges that hold nothing, raw or after clamping
  task automatic add_empty_query();
    int b, e;
    if ($urandom_range(0, 2) == 0) begin
      b = $urandom_range(DEPTH + 1, RANGE_TOP);
      e = $urandom_range(b, RANGE_TOP);
    end else begin
      e = $urandom_range(0, RANGE_TOP - 1);
      b = $urandom_range(e + 1, RANGE_TOP);
    end
    add_query(b, e);
  endtask

  task automatic add_write_burst();
    int base, len;
    len = $urandom_range(1, 8);
    if ($urandom_range(0, 3) == 0) begin
      base = $urandom_range(0, DEPTH - 1);
    end else begin
      base = frontier;
      frontier = (frontier + len) % DEPTH;
    end
    for (int i = 0; i < len; i++) add_write((base + i) % DEPTH, pick_value());
  endtask

  // ---------------------------------------------------------------- predictor

  // kadane scan over the clamped one-based range, sums kept as longint and cut to the result width
  function automatic range_sum_t max_range_sum(input logic [RANGE_W-1:0] rb,
                                               input logic [RANGE_W-1:0] re);
    range_sum_t r;
    longint     best, run;
    int         first, last;
    first = (rb < 1) ? 1 : int'(rb);
    last  = (re > DEPTH) ? DEPTH : int'(re);
    best  = longint'(SUM_MOST_NEG);
    run   = 0;
    r.empty = 1'b1;
    for (int k = first; k <= last; k++) begin
      run += longint'(shadow_store[k - 1]);
      if (r.empty || run > best) best = run;
      r.empty = 1'b0;
      if (run < 0) run = 0;
    end
    if (last - first + 1 > widest_scan) widest_scan = last - first + 1;
    r.sum = best[SUM_W-1:0];
    return r;
  endfunction

  task automatic apply_item(input unit_item_t it);
    if (it.op == OP_WRITE) begin
      shadow_store[it.idx] = it.val;
      writes_done++;
    end else begin
      sums_due.push_back(max_range_sum(it.rbeg, it.rend));
      queries_done++;
    end
  endtask

  // ---------------------------------------------------------------- input driver

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_tdata  <= {cur_item.rend, cur_item.rbeg, cur_item.val, cur_item.idx};
          in_tuser  <= cur_item.op;
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 31) == 0) in_idle_mode = !in_idle_mode;
          if (in_idle_mode && pending_items.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0)
            in_gap = $urandom_range(1, 19);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result back-pressure

  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 99) == 0) out_idle_mode = !out_idle_mode;
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else if (out_idle_mode && pending_items.size() >= TAIL_ITEMS &&
                   $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        out_stall = $urandom_range(0, 18);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  range_sum_t due;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) apply_item(cur_item);
      if (out_tvalid && out_tready) begin
        if (sums_due.size() == 0) begin
          report_mismatch("result transfer with no query waiting");
        end else begin
          due = sums_due.pop_front();
          if (out_tdata !== due.sum)
            report_mismatch($sformatf("best_sum %0d, expected %0d",
                                      $signed(out_tdata), $signed(due.sum)));
          if (out_tuser !== due.empty)
            report_mismatch($sformatf("range_empty %b, expected %b", out_tuser, due.empty));
          if (due.empty) empties_checked++;
          else sums_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sums_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus and run control

  initial begin
    int dice;

    // directed: extreme values, mixed signs, clamping and empty ranges
    add_write(0, 32'h7FFF_FFFF);
    add_write(1, 32'h8000_0000);
    add_write(2, 32'hFFFF_FFFF);
    add_write(3, 32'h0000_0000);
    add_write(4, 32'h7FFF_FFFF);
    add_write(5, 32'h7FFF_FFFF);
    add_write(6, 32'h0000_0005);
    add_write(7, 32'h8000_0000);
    add_write(DEPTH - 1, 32'h8000_0000);
    add_write(DEPTH - 2, 32'hFFFF_FFFF);
    add_query(1, 8);                  // mixed run over the written head
    add_query(0, 8);                  // begin below one
    add_query(2, 2);                  // single most negative element
    add_query(2, 3);                  // all negative, best is the largest element
    add_query(5, 6);                  // two maximal positives, sum beyond 32 bits
    add_query(5, 4);                  // begin after end
    add_query(RANGE_TOP, RANGE_TOP);  // empty once clamped to the store
    add_query(DEPTH - 1, RANGE_TOP);  // end past the store
    add_query(DEPTH, DEPTH);          // last entry only
    add_query(1500, RANGE_TOP);       // begin past the store
    frontier = 8;

    // random: mostly write bursts and queries over written stretches, some empty ranges
    while (items_built < 20 + RANDOM_ITEMS) begin
      dice = $urandom_range(0, 99);
      if (dice < 40) add_write_burst();
      else if (dice < 88) add_span_query();
      else add_empty_query();
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_tvalid) @(posedge clk);
    while (sums_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d element writes and %0d range queries sent, widest scan %0d elements",
             writes_done, queries_done, widest_scan);
    $display("%0d sums and %0d empty ranges compared in %0d cycles",
             sums_checked, empties_checked, cycle_count);
    if (mismatches == 0 && sums_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rmss_pkg.sv
hw/rtl/rmss_ctrl.sv
hw/rtl/rmss_dp.sv
hw/rtl/range_max_subarray_sum_unit.sv
sim/testbench.sv
